/* rtl/core/gda_pkg.sv */
// gda_pkg: shared types, constants and calendar helpers for the gregorian date unit
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package gda_pkg;

  localparam int YEAR_MAX_DEF = 9999;

  // serial day number, internal year and year-in-era widths
  localparam int SW = 24;
  localparam int YW = 16;
  localparam int KW = 9;

  localparam logic [SW-1:0] ERA_DAYS  = 24'd146097;
  localparam logic [YW-1:0] ERA_YEARS = 16'd400;
  localparam logic [8:0]    YEAR_DAYS = 9'd365;
  localparam logic [21:0]   DIFF_MAX  = 22'h3FFFFF;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DIFF = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_FIRST_BAD  = 3'd1;
  localparam logic [2:0] ST_SECOND_BAD = 3'd2;
  localparam logic [2:0] ST_LATER      = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_LOAD     = 4'd1;
  localparam logic [3:0] CMD_FWD_INIT = 4'd2;
  localparam logic [3:0] CMD_ERA_F    = 4'd3;
  localparam logic [3:0] CMD_YEAR_F   = 4'd4;
  localparam logic [3:0] CMD_DOY      = 4'd5;
  localparam logic [3:0] CMD_REV_INIT = 4'd6;
  localparam logic [3:0] CMD_ERA_R    = 4'd7;
  localparam logic [3:0] CMD_YEAR_R   = 4'd8;
  localparam logic [3:0] CMD_MON_R    = 4'd9;
  localparam logic [3:0] CMD_FIN_ADD  = 4'd10;
  localparam logic [3:0] CMD_FIN_CMP  = 4'd11;
  localparam logic [3:0] CMD_FIN_ERR  = 4'd12;
  localparam logic [3:0] CMD_PUBLISH  = 4'd13;

  typedef struct packed {
    logic        operation;
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
    logic [21:0] days_to_add;
  } gda_in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic [21:0] day_difference;
    logic [2:0]  status;
  } gda_out_t;

  typedef struct packed {
    logic [3:0] op;
    logic       sel;
  } gda_cmd_t;

  typedef struct packed {
    logic oper;
    logic era_f_ge;
    logic year_f_more;
    logic date_bad;
    logic era_r_ge;
    logic year_r_more;
    logic mon_more;
  } gda_sts_t;

  // leap rule for a year counted from the start of a 400-year era
  function automatic logic leap_in_era(input logic [KW-1:0] k);
    return (k[1:0] == 2'b00) && (k != 9'd100) && (k != 9'd200) && (k != 9'd300);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, leap && (m > 4'd2)};
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gda_in_if.sv */
// gda_in_if: valid/ready channel carrying one date request item
// depends on gda_pkg for the payload type
`default_nettype none

interface gda_in_if;
  import gda_pkg::*;

  logic    valid;
  logic    ready;
  gda_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/gda_out_if.sv */
// gda_out_if: valid/ready channel carrying one date result item
// depends on gda_pkg for the payload type
`default_nettype none

interface gda_out_if;
  import gda_pkg::*;

  logic     valid;
  logic     ready;
  gda_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/gda_dpath.sv */
// gda_dpath: serial day accumulator, year/era/month counters and result registers
// steered by gda_ctrl commands; depends on gda_pkg
`default_nettype none

module gda_dpath #(
  parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
  input  logic              clk,
  input  gda_pkg::gda_in_t  in_data,
  input  gda_pkg::gda_cmd_t cmd,
  output gda_pkg::gda_sts_t sts,
  output gda_pkg::gda_out_t out_data
);
  import gda_pkg::*;

  gda_in_t         req_r;
  logic            sel_r;
  logic [SW-1:0]   acc_r;
  logic [SW-1:0]   s1_r;
  logic [YW-1:0]   yr_r;
  logic [KW-1:0]   k_r;
  logic [3:0]      mon_r;
  gda_out_t        res_r;
  gda_out_t        out_r;

  logic [4:0]      cur_d;
  logic [3:0]      cur_m;
  logic [13:0]     cur_y;
  logic            leap_k;
  logic [8:0]      ylen;
  logic [4:0]      mlen_cur;
  logic [4:0]      mlen_mon;
  logic [SW-1:0]   doy_sum;
  logic [YW-1:0]   ry;
  logic [SW-1:0]   diff;
  gda_out_t        res_add;
  gda_out_t        res_cmp;
  gda_out_t        res_err;

  always_comb begin
    cur_d    = sel_r ? req_r.second_day   : req_r.first_day;
    cur_m    = sel_r ? req_r.second_month : req_r.first_month;
    cur_y    = sel_r ? req_r.second_year  : req_r.first_year;
    leap_k   = leap_in_era(k_r);
    ylen     = YEAR_DAYS + {8'd0, leap_k};
    mlen_cur = month_len(cur_m, leap_k);
    mlen_mon = month_len(mon_r, leap_k);
    doy_sum  = acc_r + SW'(days_before_month(cur_m, leap_k)) + SW'(cur_d) - SW'(1);
    ry       = yr_r + YW'(k_r);
    diff     = s1_r - acc_r;
  end

  // finished result for each way an item can end
  always_comb begin
    res_add = '0;
    if (ry > YW'(YEAR_MAX)) begin
      res_add.status = ST_OVERFLOW;
    end else begin
      res_add.result_day   = acc_r[4:0] + 5'd1;
      res_add.result_month = mon_r;
      res_add.result_year  = ry[13:0];
      res_add.status       = ST_OK;
    end
    res_cmp = '0;
    if (acc_r > s1_r) begin
      res_cmp.status = ST_LATER;
    end else if (diff > SW'(DIFF_MAX)) begin
      res_cmp.day_difference = DIFF_MAX;
      res_cmp.status         = ST_OK;
    end else begin
      res_cmp.day_difference = diff[21:0];
      res_cmp.status         = ST_OK;
    end
    res_err        = '0;
    res_err.status = sel_r ? ST_SECOND_BAD : ST_FIRST_BAD;
  end

  always_comb begin
    sts.oper        = req_r.operation;
    sts.era_f_ge    = yr_r >= ERA_YEARS;
    sts.year_f_more = k_r != yr_r[KW-1:0];
    sts.date_bad    = (cur_m == 4'd0) || (cur_m > 4'd12) || (YW'(cur_y) > YW'(YEAR_MAX))
                   || (cur_d == 5'd0) || (cur_d > mlen_cur);
    sts.era_r_ge    = acc_r >= ERA_DAYS;
    sts.year_r_more = acc_r >= SW'(ylen);
    sts.mon_more    = acc_r >= SW'(mlen_mon);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        req_r <= in_data;
      end
      CMD_FWD_INIT: begin
        sel_r <= cmd.sel;
        acc_r <= '0;
        yr_r  <= YW'(sel_r == cmd.sel ? cur_y
                     : (cmd.sel ? req_r.second_year : req_r.first_year));
        k_r   <= '0;
      end
      CMD_ERA_F: begin
        acc_r <= acc_r + ERA_DAYS;
        yr_r  <= yr_r - ERA_YEARS;
      end
      CMD_YEAR_F: begin
        acc_r <= acc_r + SW'(ylen);
        k_r   <= k_r + KW'(1);
      end
      CMD_DOY: begin
        acc_r <= doy_sum;
        if (!sel_r) begin
          s1_r <= doy_sum;
        end
      end
      CMD_REV_INIT: begin
        acc_r <= s1_r + SW'(req_r.days_to_add);
        yr_r  <= '0;
        k_r   <= '0;
        mon_r <= 4'd1;
      end
      CMD_ERA_R: begin
        acc_r <= acc_r - ERA_DAYS;
        yr_r  <= yr_r + ERA_YEARS;
      end
      CMD_YEAR_R: begin
        acc_r <= acc_r - SW'(ylen);
        k_r   <= k_r + KW'(1);
      end
      CMD_MON_R: begin
        acc_r <= acc_r - SW'(mlen_mon);
        mon_r <= mon_r + 4'd1;
      end
      CMD_FIN_ADD: begin
        res_r <= res_add;
      end
      CMD_FIN_CMP: begin
        res_r <= res_cmp;
      end
      CMD_FIN_ERR: begin
        res_r <= res_err;
      end
      CMD_PUBLISH: begin
        out_r <= res_r;
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

/* rtl/core/gda_ctrl.sv */
// gda_ctrl: sequencer for the date unit, walks eras, years and months one step a cycle
// drives gda_dpath through command codes from gda_pkg and owns the channel handshakes
`default_nettype none

module gda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  gda_pkg::gda_sts_t sts,
  output gda_pkg::gda_cmd_t cmd
);
  import gda_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_F_INIT = 4'd1;
  localparam logic [3:0] S_F_ERA  = 4'd2;
  localparam logic [3:0] S_F_YEAR = 4'd3;
  localparam logic [3:0] S_F_DOY  = 4'd4;
  localparam logic [3:0] S_R_INIT = 4'd5;
  localparam logic [3:0] S_R_ERA  = 4'd6;
  localparam logic [3:0] S_R_YEAR = 4'd7;
  localparam logic [3:0] S_R_MON  = 4'd8;
  localparam logic [3:0] S_CMP    = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = CMD_NONE;
    cmd.sel       = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = CMD_LOAD;
          sel_nxt   = 1'b0;
          state_nxt = S_F_INIT;
        end
      end
      S_F_INIT: begin
        cmd.op    = CMD_FWD_INIT;
        state_nxt = S_F_ERA;
      end
      S_F_ERA: begin
        if (sts.era_f_ge) begin
          cmd.op = CMD_ERA_F;
        end else begin
          state_nxt = S_F_YEAR;
        end
      end
      S_F_YEAR: begin
        if (sts.year_f_more) begin
          cmd.op = CMD_YEAR_F;
        end else begin
          state_nxt = S_F_DOY;
        end
      end
      S_F_DOY: begin
        if (sts.date_bad) begin
          cmd.op    = CMD_FIN_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.op = CMD_DOY;
          if (sel_r) begin
            state_nxt = S_CMP;
          end else if (sts.oper == OP_DIFF) begin
            sel_nxt   = 1'b1;
            state_nxt = S_F_INIT;
          end else begin
            state_nxt = S_R_INIT;
          end
        end
      end
      S_R_INIT: begin
        cmd.op    = CMD_REV_INIT;
        state_nxt = S_R_ERA;
      end
      S_R_ERA: begin
        if (sts.era_r_ge) begin
          cmd.op = CMD_ERA_R;
        end else begin
          state_nxt = S_R_YEAR;
        end
      end
      S_R_YEAR: begin
        if (sts.year_r_more) begin
          cmd.op = CMD_YEAR_R;
        end else begin
          state_nxt = S_R_MON;
        end
      end
      S_R_MON: begin
        if (sts.mon_more) begin
          cmd.op = CMD_MON_R;
        end else begin
          cmd.op    = CMD_FIN_ADD;
          state_nxt = S_DONE;
        end
      end
      S_CMP: begin
        cmd.op    = CMD_FIN_CMP;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = CMD_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_publish_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_PUBLISH |-> (!out_valid_r || out_ready))
    else $error("result published over an untaken result");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> cmd.op == CMD_LOAD)
    else $error("accepted item not loaded");

  a_publish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_PUBLISH |=> (state_r == S_IDLE && out_valid_r))
    else $error("publish did not return to idle with a valid result");

  a_cmp_diff_only: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (sel_r && sts.oper == OP_DIFF))
    else $error("compare reached outside a difference item");

  a_rev_add_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == CMD_REV_INIT |-> (!sel_r && sts.oper == OP_ADD))
    else $error("date rebuild started outside an add item");

endmodule

`default_nettype wire

/* rtl/core/gregorian_date_add_and_difference.sv */
// gregorian_date_add_and_difference: top level of the gregorian date arithmetic unit
// depends on gda_pkg, gda_in_if, gda_out_if, gda_ctrl and gda_dpath
//
// usage:
//   in_ch carries one item: an add of days_to_add to the first date (operation 0)
//   or the day count from the second date up to the first (operation 1).
//   out_ch returns exactly one result item per accepted item, with status.
//   in_ch.ready is high only while the unit is idle; one item is worked at a time.
//   each date is turned into a day number by stepping 400-year eras, then single
//   years, one step a cycle; an add then rebuilds the date by stepping eras, years
//   and months. the era, year and month step loops and any wait on the receiver set how long a full item takes.
//   the finished result sits in an output register; the next item is accepted
//   while it waits. a result that finds the register still full holds until the
//   receiver takes the earlier one, so a stalled receiver never loses an item.
//   rst_n is synchronous, active low: the unit returns to idle, out_ch.valid drops.
`default_nettype none

module gregorian_date_add_and_difference #(
  parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  gda_in_if.sink           in_ch,
  gda_out_if.source        out_ch
);
  import gda_pkg::*;

  gda_cmd_t cmd;
  gda_sts_t sts;
  logic     in_ready;
  logic     out_valid;
  gda_out_t out_data;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gda_dpath #(
    .YEAR_MAX (YEAR_MAX)
  ) u_dpath (
    .clk      (clk),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

`default_nettype wire

/* bench/gda_date_checker.sv */
// gda_date_checker: watches the request and result channels of the date unit,
// predicts each result from the calendar rules and compares it field by field
// depends on gda_pkg, gda_in_if and gda_out_if
module gda_date_checker #(
  parameter int YEAR_MAX = gda_pkg::YEAR_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  gda_in_if    in_mon,
  gda_out_if   out_mon,
  output int   error_count,
  output int   results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import gda_pkg::*;

  gda_out_t due_results[$];
  gda_out_t oldest;
  int       failures = 0;
  int       due_now = 0;

  assign error_count = failures;
  assign results_due = due_now;

  function automatic bit is_leap(longint unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint unsigned month_span(longint unsigned m, longint unsigned y);
    case (m)
      2:          return is_leap(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic bit date_valid(longint unsigned d, longint unsigned m,
                                    longint unsigned y);
    if (m < 1 || m > 12 || y > 64'(YEAR_MAX) || d < 1) return 1'b0;
    return d <= month_span(m, y);
  endfunction

  // day count with the year moved up 400 so every term stays non-negative
  function automatic longint unsigned day_serial(longint unsigned d, longint unsigned m,
                                                 longint unsigned y);
    longint unsigned yy, era, yoe, mp, doy, doe;
    yy  = y + 400 - ((m <= 2) ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m + 9) % 12;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe;
  endfunction

  function automatic void serial_to_date(input longint unsigned z,
                                         output longint unsigned d,
                                         output longint unsigned m,
                                         output longint unsigned y);
    longint unsigned era, doe, yoe, doy, mp, yr;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    yr  = yoe + era * 400;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) yr = yr + 1;
    y   = yr - 400;
  endfunction

  function automatic gda_out_t calendar_result(gda_in_t req);
    gda_out_t        res;
    longint unsigned d, m, y, s1, s2, span;
    longint unsigned d1, m1, y1, d2, m2, y2, add;
    d1  = 64'(req.first_day);
    m1  = 64'(req.first_month);
    y1  = 64'(req.first_year);
    d2  = 64'(req.second_day);
    m2  = 64'(req.second_month);
    y2  = 64'(req.second_year);
    add = 64'(req.days_to_add);
    res = '0;
    res.status = ST_OK;
    if (!date_valid(d1, m1, y1)) begin
      res.status = ST_FIRST_BAD;
    end else if (req.operation == OP_ADD) begin
      serial_to_date(day_serial(d1, m1, y1) + add, d, m, y);
      if (y > 64'(YEAR_MAX)) begin
        res.status = ST_OVERFLOW;
      end else begin
        res.result_day   = d[4:0];
        res.result_month = m[3:0];
        res.result_year  = y[13:0];
      end
    end else if (!date_valid(d2, m2, y2)) begin
      res.status = ST_SECOND_BAD;
    end else begin
      s1 = day_serial(d1, m1, y1);
      s2 = day_serial(d2, m2, y2);
      if (s2 > s1) begin
        res.status = ST_LATER;
      end else begin
        span = s1 - s2;
        res.day_difference = (span > 64'(DIFF_MAX)) ? DIFF_MAX : span[21:0];
      end
    end
    return res;
  endfunction

  task automatic note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) note_failure($sformatf("%s expected %0d got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_results.size() == 0) begin
          note_failure($sformatf("result item with nothing pending, status %0d",
                                 out_mon.data.status));
        end else begin
          oldest = due_results.pop_front();
          compare_field("result_day", 64'(oldest.result_day),
                        64'(out_mon.data.result_day));
          compare_field("result_month", 64'(oldest.result_month),
                        64'(out_mon.data.result_month));
          compare_field("result_year", 64'(oldest.result_year),
                        64'(out_mon.data.result_year));
          compare_field("day_difference", 64'(oldest.day_difference),
                        64'(out_mon.data.day_difference));
          compare_field("status", 64'(oldest.status), 64'(out_mon.data.status));
        end
      end
      if (in_mon.valid && in_mon.ready) due_results.push_back(calendar_result(in_mon.data));
    end
    due_now = due_results.size();
  end

endmodule

/* bench/tb_top.sv */
// tb_top: drives date requests into the gregorian date unit with random idling
// on both channels; the verdict comes from the checker's failure and pending counts and a stall watchdog
// depends on gda_pkg, gda_in_if, gda_out_if, gda_date_checker and the unit itself
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gda_pkg::*;

  localparam int YEAR_MAX     = YEAR_MAX_DEF;
  localparam int RANDOM_ITEMS = 75;
  localparam int STALL_LIMIT  = 8000;
  localparam int SETTLE       = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;
  int   error_count;
  int   results_due;
  int   hold_off = 0;

  gda_in_if  in_ch();
  gda_out_if out_ch();

  gregorian_date_add_and_difference #(.YEAR_MAX(YEAR_MAX)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gda_date_checker #(.YEAR_MAX(YEAR_MAX)) checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .error_count (error_count),
    .results_due (results_due)
  );

  always #4 clk = ~clk;

  // receiver stalls in bursts of random length
  always @(negedge clk) begin
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= $urandom_range(0, 3);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [4:0] month_days(logic [3:0] m, logic [13:0] y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      4'd2:                      return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  function automatic logic [13:0] pick_year();
    case ($urandom_range(0, 5))
      0:       return 14'($urandom_range(0, 3));
      1:       return 14'(YEAR_MAX - int'($urandom_range(0, 3)));
      2:       return 14'($urandom_range(0, 99) * 100);
      default: return 14'($urandom_range(0, YEAR_MAX));
    endcase
  endfunction

  function automatic void pick_day_month(input logic [13:0] y, output logic [4:0] d,
                                         output logic [3:0] m);
    m = 4'($urandom_range(1, 12));
    if ($urandom_range(0, 4) == 0) d = month_days(m, y);
    else d = 5'($urandom_range(1, 32'(month_days(m, y))));
  endfunction

  function automatic gda_in_t make_request(logic op, int d1, int m1, int y1,
                                           int d2, int m2, int y2, int days);
    gda_in_t req;
    req.operation    = op;
    req.first_day    = 5'(d1);
    req.first_month  = 4'(m1);
    req.first_year   = 14'(y1);
    req.second_day   = 5'(d2);
    req.second_month = 4'(m2);
    req.second_year  = 14'(y2);
    req.days_to_add  = 22'(days);
    return req;
  endfunction

  function automatic gda_in_t random_request();
    gda_in_t     req;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    req.operation = $urandom_range(0, 1) ? OP_DIFF : OP_ADD;
    if ($urandom_range(0, 99) < 85) begin
      y = pick_year();
      pick_day_month(y, d, m);
      req.first_day   = d;
      req.first_month = m;
      req.first_year  = y;
    end else begin
      req.first_day   = 5'($urandom);
      req.first_month = 4'($urandom);
      req.first_year  = 14'($urandom);
    end
    case ($urandom_range(0, 9))
      0: begin
        req.second_day   = 5'($urandom);
        req.second_month = 4'($urandom);
        req.second_year  = 14'($urandom);
      end
      1, 2: begin
        y = pick_year();
        pick_day_month(y, d, m);
        req.second_day   = d;
        req.second_month = m;
        req.second_year  = y;
      end
      default: begin
        // mostly an earlier second date, sometimes in the same year
        if ($urandom_range(0, 2) == 0 && 32'(req.first_year) <= YEAR_MAX) y = req.first_year;
        else y = 14'($urandom_range(0, (32'(req.first_year) > YEAR_MAX) ? YEAR_MAX
                                                                        : 32'(req.first_year)));
        pick_day_month(y, d, m);
        req.second_day   = d;
        req.second_month = m;
        req.second_year  = y;
      end
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: req.days_to_add = 22'($urandom_range(0, 400));
      4, 5, 6:    req.days_to_add = 22'($urandom_range(0, 100000));
      7:          req.days_to_add = 22'($urandom_range(3000000, 4194303));
      default:    req.days_to_add = 22'($urandom);
    endcase
    return req;
  endfunction

  task automatic send_request(gda_in_t req);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= req;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // date extremes, leap rules, bad dates and each status
    send_request(make_request(OP_ADD, 1, 1, 0, 0, 0, 0, 0));
    send_request(make_request(OP_ADD, 1, 1, 0, 0, 0, 0, 4194303));
    send_request(make_request(OP_ADD, 31, 12, 9999, 0, 0, 0, 0));
    send_request(make_request(OP_ADD, 31, 12, 9999, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 1, 1, 9999, 0, 0, 0, 364));
    send_request(make_request(OP_ADD, 28, 2, 2000, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 28, 2, 1900, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 29, 2, 2004, 0, 0, 0, 365));
    send_request(make_request(OP_ADD, 31, 1, 2023, 0, 0, 0, 30));
    send_request(make_request(OP_ADD, 15, 8, 1999, 31, 15, 16383, 1));
    send_request(make_request(OP_ADD, 0, 5, 2020, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 10, 0, 2020, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 10, 13, 2020, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 31, 15, 16383, 31, 15, 16383, 4194303));
    send_request(make_request(OP_ADD, 31, 4, 2021, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 29, 2, 1900, 0, 0, 0, 1));
    send_request(make_request(OP_ADD, 10, 6, 10000, 0, 0, 0, 1));
    send_request(make_request(OP_DIFF, 1, 1, 0, 1, 1, 0, 0));
    send_request(make_request(OP_DIFF, 31, 12, 9999, 1, 1, 0, 0));
    send_request(make_request(OP_DIFF, 1, 3, 2000, 28, 2, 2000, 0));
    send_request(make_request(OP_DIFF, 1, 1, 2000, 2, 1, 2000, 0));
    send_request(make_request(OP_DIFF, 15, 6, 2000, 0, 1, 1999, 0));
    send_request(make_request(OP_DIFF, 30, 2, 2000, 1, 1, 1999, 0));
    send_request(make_request(OP_DIFF, 1, 1, 2200, 29, 2, 2100, 0));
    send_request(make_request(OP_DIFF, 1, 1, 2200, 5, 13, 2100, 0));
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 40 && i < 55) || (i >= RANDOM_ITEMS - 15);
      if (i == 60) drain_results();
      send_request(random_request());
    end
    drain_results();
    repeat (SETTLE) @(negedge clk);

    if (error_count == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/gda_pkg.sv
rtl/core/gda_in_if.sv
rtl/core/gda_out_if.sv
rtl/core/gda_dpath.sv
rtl/core/gda_ctrl.sv
rtl/core/gregorian_date_add_and_difference.sv
bench/gda_date_checker.sv
bench/tb_top.sv
